@@ rtl/felog_pkg.sv @@
// Package for the flash EEPROM emulation log core.
// Item types, operation/result codes and memory command struct; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package felog_pkg;

    localparam logic [2:0] FUNC_RDBYTE  = 3'd0;
    localparam logic [2:0] FUNC_RDWORD  = 3'd1;
    localparam logic [2:0] FUNC_WRBYTE  = 3'd2;
    localparam logic [2:0] FUNC_WRWORD  = 3'd3;
    localparam logic [2:0] FUNC_LOAD    = 3'd4;
    localparam logic [2:0] FUNC_REPLAY  = 3'd5;
    localparam logic [2:0] FUNC_ERASE   = 3'd6;
    localparam logic [2:0] FUNC_IMAGE   = 3'd7;

    localparam logic [2:0] KIND_FINAL   = 3'd0;
    localparam logic [2:0] KIND_PROG    = 3'd1;
    localparam logic [2:0] KIND_LOG     = 3'd2;
    localparam logic [2:0] KIND_COMPACT = 3'd3;
    localparam logic [2:0] KIND_ERASE   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNCHANGED = 2'd1;
    localparam logic [1:0] ST_BAD       = 2'd2;

    localparam logic [15:0] BLANK       = 16'hFFFF;
    localparam logic [13:0] BYTE_RANGE  = 14'h0080;
    localparam logic [12:0] NEXT_OFFSET = 13'd64;

    typedef struct packed {
        logic [2:0]  func;
        logic [13:0] address;
        logic [15:0] data;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [12:0] word_index;
        logic [15:0] data_res;
        logic [1:0]  status;
        logic        last;
    } res_t;

    typedef struct packed {
        logic        cache_we;
        logic        prog_we;
        logic [12:0] waddr;
        logic [15:0] cache_wdata;
        logic        prog_wdata;
        logic [12:0] raddr;
    } mem_cmd_t;

endpackage

`default_nettype wire

@@ rtl/felog_store.sv @@
// Word cache and compacted-programmed bit memories, one write and one read port each.
// Uses felog_pkg (mem_cmd_t); read data registered.
`timescale 1ns / 1ps
`default_nettype none

module felog_store
    import felog_pkg::*;
#(
    parameter int WORDS = 1024
) (
    input  wire logic        clk,
    input  wire mem_cmd_t    cmd,
    output logic [15:0]      cache_rdata,
    output logic             prog_rdata
);

    localparam int AW = $clog2(WORDS);

    logic [15:0] cache_mem [WORDS];
    logic        prog_mem  [WORDS];

    always_ff @(posedge clk)
    begin
        if (cmd.cache_we)
        begin
            cache_mem[cmd.waddr[AW-1:0]] <= cmd.cache_wdata;
        end
        cache_rdata <= cache_mem[cmd.raddr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prog_we)
        begin
            prog_mem[cmd.waddr[AW-1:0]] <= cmd.prog_wdata;
        end
        prog_rdata <= prog_mem[cmd.raddr[AW-1:0]];
    end

endmodule

`default_nettype wire

@@ rtl/flash_eeprom_emulation_log_core.sv @@
// Top level of the flash EEPROM emulation log core: controller state machine.
// Uses felog_pkg and felog_store.
`timescale 1ns / 1ps
`default_nettype none

// An item is taken when start is high and busy is low; every item yields one to five
// results on result, each valid for exactly one cycle with result_valid, the last one
// marked by result.last. The receiver cannot stall. Timing is set by the single read
// port of the cache memory; a write can trigger compaction, which sweeps the whole
// cache before the write completes, and an erase clears the memories. After reset the
// block clears its memories with busy high before taking the first item.

module flash_eeprom_emulation_log_core
    import felog_pkg::*;
#(
    parameter int DENSITY_BYTES = 2048,
    parameter int LOG_WORDS     = 1024
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire item_t cmd,
    output logic       busy,
    output logic       result_valid,
    output res_t       result
);

    localparam int CW  = (DENSITY_BYTES + 1) / 2;
    localparam int CNW = $clog2(CW + 1);
    localparam int SW  = $clog2(LOG_WORDS + 1);

    localparam logic [14:0]    DENS_LIM = 15'(DENSITY_BYTES);
    localparam logic [14:0]    CW_LIM   = 15'(CW);
    localparam logic [SW:0]    LOG_LIM  = (SW+1)'(LOG_WORDS);
    localparam logic [CNW-1:0] CNT_END  = CNW'(CW);
    localparam logic [CNW-1:0] CNT_LAST = CNW'(CW - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD1, S_RD2, S_WB, S_WW, S_LOGW2, S_SWEEP, S_STEP, S_REP, S_FINAL
    } state_t;

    typedef enum logic [1:0] {LG_NONE, LG_BYTE, LG_WORD} lg_sel_t;

    state_t       state_reg, state_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic         fin_reg, fin_next;
    logic [2:0]   func_reg, func_next;
    logic [13:0]  addr_reg, addr_next;
    logic [15:0]  data_reg, data_next;
    logic [13:0]  cur_a_reg, cur_a_next;
    logic [7:0]   cur_b_reg, cur_b_next;
    logic         second_reg, second_next;
    logic [1:0]   s1_reg, s1_next;
    logic [1:0]   st_reg, st_next;
    logic [15:0]  rd_reg, rd_next;
    logic         pend_b2_reg, pend_b2_next;
    logic [15:0]  lw_v_reg, lw_v_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic         replay_done_reg, replay_done_next;
    logic         pending_reg, pending_next;
    logic [12:0]  pwa_reg, pwa_next;
    res_t         res_reg, res_next;
    logic         valid_reg, valid_next;

    mem_cmd_t     mem;
    logic [15:0]  rw;
    logic         rp;

    felog_store #(.WORDS(CW)) u_store (
        .clk         (clk),
        .cmd         (mem),
        .cache_rdata (rw),
        .prog_rdata  (rp)
    );

    // write-path helpers
    logic [7:0]  wb_old;
    logic        wb_same;
    logic [15:0] wb_nw;
    logic        ww_same, lowc, highc;

    assign wb_old  = cur_a_reg[0] ? rw[15:8] : rw[7:0];
    assign wb_same = (wb_old == cur_b_reg);
    assign wb_nw   = cur_a_reg[0] ? {cur_b_reg, rw[7:0]} : {rw[15:8], cur_b_reg};
    assign ww_same = (rw == data_reg);
    assign lowc    = (rw[7:0] != data_reg[7:0]);
    assign highc   = (rw[15:8] != data_reg[15:8]);

    // log entry selection
    lg_sel_t     lg_sel;
    logic [6:0]  lg_a7;
    logic [7:0]  lg_b;
    logic [12:0] lg_widx;
    logic [15:0] lg_v;

    always_comb
    begin
        lg_sel  = LG_NONE;
        lg_a7   = '0;
        lg_b    = '0;
        lg_widx = '0;
        lg_v    = '0;
        case (state_reg)
            S_WB:
            begin
                if (!wb_same && rp)
                begin
                    if (cur_a_reg < BYTE_RANGE)
                    begin
                        lg_sel = LG_BYTE;
                        lg_a7  = cur_a_reg[6:0];
                        lg_b   = cur_b_reg;
                    end
                    else
                    begin
                        lg_sel  = LG_WORD;
                        lg_widx = cur_a_reg[13:1];
                        lg_v    = wb_nw;
                    end
                end
            end
            S_WW:
            begin
                if (!ww_same && rp)
                begin
                    if (addr_reg < BYTE_RANGE)
                    begin
                        lg_sel = LG_BYTE;
                        if (lowc)
                        begin
                            lg_a7 = addr_reg[6:0];
                            lg_b  = data_reg[7:0];
                        end
                        else
                        begin
                            lg_a7 = {addr_reg[6:1], 1'b1};
                            lg_b  = data_reg[15:8];
                        end
                    end
                    else
                    begin
                        lg_sel  = LG_WORD;
                        lg_widx = addr_reg[13:1];
                        lg_v    = data_reg;
                    end
                end
            end
            S_STEP:
            begin
                if (pend_b2_reg)
                begin
                    lg_sel = LG_BYTE;
                    lg_a7  = {addr_reg[6:1], 1'b1};
                    lg_b   = data_reg[15:8];
                end
            end
            default:
            begin
                lg_sel = LG_NONE;
            end
        endcase
    end

    // log entry encoding and log-full check
    logic        lg_two, lg_compact;
    logic [15:0] lg_data;
    logic [SW:0] slot_ext;

    assign slot_ext = {1'b0, slot_reg};
    assign lg_two   = (lg_sel == LG_WORD) && (lg_v > 16'd1);

    always_comb
    begin
        lg_compact = 1'b0;
        lg_data    = '0;
        case (lg_sel)
            LG_BYTE:
            begin
                lg_compact = (slot_ext >= LOG_LIM);
                lg_data    = {1'b0, lg_a7, lg_b};
            end
            LG_WORD:
            begin
                lg_compact = ((slot_ext + (lg_two ? (SW+1)'(2) : (SW+1)'(1))) > LOG_LIM);
                lg_data    = lg_two ? {3'b111, lg_widx - NEXT_OFFSET}
                                    : {2'b10, lg_v[0], lg_widx};
            end
            default:
            begin
                lg_compact = 1'b0;
            end
        endcase
    end

    logic [14:0] a_ext, a1_ext, pidx, d12_ext;

    assign a_ext   = {1'b0, cmd.address};
    assign a1_ext  = {1'b0, addr_reg} + 15'd1;
    assign pidx    = {2'b00, pwa_reg} + {2'b00, NEXT_OFFSET};
    assign d12_ext = {2'b00, cmd.data[12:0]};

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        fin_next         = fin_reg;
        func_next        = func_reg;
        addr_next        = addr_reg;
        data_next        = data_reg;
        cur_a_next       = cur_a_reg;
        cur_b_next       = cur_b_reg;
        second_next      = second_reg;
        s1_next          = s1_reg;
        st_next          = st_reg;
        rd_next          = rd_reg;
        pend_b2_next     = pend_b2_reg;
        lw_v_next        = lw_v_reg;
        slot_next        = slot_reg;
        replay_done_next = replay_done_reg;
        pending_next     = pending_reg;
        pwa_next         = pwa_reg;
        res_next         = '0;
        valid_next       = 1'b0;
        mem              = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem.cache_we = 1'b1;
                mem.prog_we  = 1'b1;
                mem.waddr    = 13'(cnt_reg);
                if (cnt_reg == CNT_LAST)
                begin
                    fin_next   = 1'b0;
                    state_next = fin_reg ? S_FINAL : S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    func_next    = cmd.func;
                    addr_next    = cmd.address;
                    data_next    = cmd.data;
                    rd_next      = '0;
                    st_next      = ST_OK;
                    second_next  = 1'b0;
                    pend_b2_next = 1'b0;
                    state_next   = S_FINAL;
                    unique case (cmd.func)
                        FUNC_RDBYTE:
                        begin
                            if (a_ext < DENS_LIM)
                            begin
                                mem.raddr  = cmd.address[13:1];
                                state_next = S_RD1;
                            end
                            else
                            begin
                                rd_next = 16'h00FF;
                                st_next = ST_BAD;
                            end
                        end
                        FUNC_RDWORD:
                        begin
                            if ((a_ext + 15'd1) < DENS_LIM)
                            begin
                                mem.raddr  = cmd.address[13:1];
                                state_next = S_RD1;
                            end
                            else
                            begin
                                rd_next = BLANK;
                                st_next = ST_BAD;
                            end
                        end
                        FUNC_IMAGE:
                        begin
                            if (a_ext < CW_LIM)
                            begin
                                mem.raddr  = cmd.address[12:0];
                                state_next = S_RD1;
                            end
                            else
                            begin
                                rd_next = BLANK;
                                st_next = ST_BAD;
                            end
                        end
                        FUNC_LOAD:
                        begin
                            if (a_ext < CW_LIM)
                            begin
                                mem.cache_we    = 1'b1;
                                mem.prog_we     = 1'b1;
                                mem.waddr       = cmd.address[12:0];
                                mem.cache_wdata = ~cmd.data;
                                mem.prog_wdata  = (cmd.data != BLANK);
                            end
                            else
                            begin
                                st_next = ST_BAD;
                            end
                        end
                        FUNC_ERASE:
                        begin
                            valid_next       = 1'b1;
                            res_next.kind    = KIND_ERASE;
                            slot_next        = '0;
                            pending_next     = 1'b0;
                            pwa_next         = '0;
                            replay_done_next = 1'b1;
                            cnt_next         = '0;
                            fin_next         = 1'b1;
                            state_next       = S_CLEAR;
                        end
                        FUNC_REPLAY:
                        begin
                            if (replay_done_reg || (slot_ext >= LOG_LIM))
                            begin
                                replay_done_next = 1'b1;
                            end
                            else if (pending_reg)
                            begin
                                pending_next = 1'b0;
                                slot_next    = slot_reg + 1'b1;
                                if ((cmd.data != BLANK) && (pidx < CW_LIM))
                                begin
                                    mem.cache_we    = 1'b1;
                                    mem.waddr       = pidx[12:0];
                                    mem.cache_wdata = ~cmd.data;
                                end
                            end
                            else if (cmd.data == BLANK)
                            begin
                                replay_done_next = 1'b1;
                            end
                            else
                            begin
                                slot_next = slot_reg + 1'b1;
                                if (!cmd.data[15])
                                begin
                                    mem.raddr  = {7'd0, cmd.data[14:9]};
                                    state_next = S_REP;
                                end
                                else if (cmd.data[14:13] == 2'b11)
                                begin
                                    if ((slot_ext + (SW+1)'(1)) >= LOG_LIM)
                                    begin
                                        replay_done_next = 1'b1;
                                    end
                                    else
                                    begin
                                        pending_next = 1'b1;
                                        pwa_next     = cmd.data[12:0];
                                    end
                                end
                                else if (!cmd.data[14] && (d12_ext < CW_LIM))
                                begin
                                    mem.cache_we    = 1'b1;
                                    mem.waddr       = cmd.data[12:0];
                                    mem.cache_wdata = {15'd0, cmd.data[13]};
                                end
                            end
                        end
                        FUNC_WRBYTE:
                        begin
                            if (a_ext < DENS_LIM)
                            begin
                                cur_a_next = cmd.address;
                                cur_b_next = cmd.data[7:0];
                                mem.raddr  = cmd.address[13:1];
                                state_next = S_WB;
                            end
                            else
                            begin
                                st_next = ST_BAD;
                            end
                        end
                        FUNC_WRWORD:
                        begin
                            if (a_ext >= DENS_LIM)
                            begin
                                st_next = ST_BAD;
                            end
                            else
                            begin
                                cur_a_next = cmd.address;
                                cur_b_next = cmd.data[7:0];
                                mem.raddr  = cmd.address[13:1];
                                state_next = cmd.address[0] ? S_WB : S_WW;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINAL;
                        end
                    endcase
                end
            end

            S_RD1:
            begin
                state_next = S_FINAL;
                case (func_reg)
                    FUNC_RDBYTE:
                    begin
                        rd_next = addr_reg[0] ? {8'd0, rw[15:8]} : {8'd0, rw[7:0]};
                    end
                    FUNC_IMAGE:
                    begin
                        rd_next = ~rw;
                    end
                    default:
                    begin
                        if (addr_reg[0])
                        begin
                            rd_next    = {8'd0, rw[15:8]};
                            mem.raddr  = a1_ext[13:1];
                            state_next = S_RD2;
                        end
                        else
                        begin
                            rd_next = rw;
                        end
                    end
                endcase
            end

            S_RD2:
            begin
                rd_next    = {rw[7:0], rd_reg[7:0]};
                state_next = S_FINAL;
            end

            S_WB, S_WW:
            begin
                state_next = S_STEP;
                if ((state_reg == S_WB) ? wb_same : ww_same)
                begin
                    st_next = ST_UNCHANGED;
                end
                else
                begin
                    st_next         = ST_OK;
                    mem.cache_we    = 1'b1;
                    mem.waddr       = (state_reg == S_WB) ? cur_a_reg[13:1] : addr_reg[13:1];
                    mem.cache_wdata = (state_reg == S_WB) ? wb_nw : data_reg;
                    if (!rp)
                    begin
                        if (mem.cache_wdata != 16'd0)
                        begin
                            mem.prog_we         = 1'b1;
                            mem.prog_wdata      = 1'b1;
                            valid_next          = 1'b1;
                            res_next.kind       = KIND_PROG;
                            res_next.word_index = mem.waddr;
                            res_next.data_res   = ~mem.cache_wdata;
                        end
                    end
                    else
                    begin
                        if ((state_reg == S_WW) && (addr_reg < BYTE_RANGE))
                        begin
                            pend_b2_next = lowc && highc;
                        end
                        valid_next = 1'b1;
                        if (lg_compact)
                        begin
                            res_next.kind    = KIND_COMPACT;
                            slot_next        = '0;
                            pending_next     = 1'b0;
                            replay_done_next = 1'b1;
                            cnt_next         = '0;
                            state_next       = S_SWEEP;
                        end
                        else
                        begin
                            res_next.kind       = KIND_LOG;
                            res_next.word_index = 13'(slot_reg);
                            res_next.data_res   = lg_data;
                            slot_next           = slot_reg + 1'b1;
                            lw_v_next           = lg_v;
                            if (lg_two)
                            begin
                                state_next = S_LOGW2;
                            end
                        end
                    end
                end
            end

            S_LOGW2:
            begin
                valid_next          = 1'b1;
                res_next.kind       = KIND_LOG;
                res_next.word_index = 13'(slot_reg);
                res_next.data_res   = ~lw_v_reg;
                slot_next           = slot_reg + 1'b1;
                state_next          = S_STEP;
            end

            S_SWEEP:
            begin
                if (cnt_reg != '0)
                begin
                    mem.prog_we    = 1'b1;
                    mem.waddr      = 13'(cnt_reg - 1'b1);
                    mem.prog_wdata = (rw != 16'd0);
                end
                if (cnt_reg == CNT_END)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    mem.raddr = 13'(cnt_reg);
                    cnt_next  = cnt_reg + 1'b1;
                end
            end

            S_STEP:
            begin
                if (pend_b2_reg)
                begin
                    pend_b2_next = 1'b0;
                    valid_next   = 1'b1;
                    if (lg_compact)
                    begin
                        res_next.kind    = KIND_COMPACT;
                        slot_next        = '0;
                        pending_next     = 1'b0;
                        replay_done_next = 1'b1;
                        cnt_next         = '0;
                        state_next       = S_SWEEP;
                    end
                    else
                    begin
                        res_next.kind       = KIND_LOG;
                        res_next.word_index = 13'(slot_reg);
                        res_next.data_res   = lg_data;
                        slot_next           = slot_reg + 1'b1;
                    end
                end
                else if ((func_reg == FUNC_WRWORD) && addr_reg[0] && !second_reg)
                begin
                    s1_next     = st_reg;
                    second_next = 1'b1;
                    if (a1_ext >= DENS_LIM)
                    begin
                        st_next    = ST_BAD;
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        cur_a_next = a1_ext[13:0];
                        cur_b_next = data_reg[15:8];
                        mem.raddr  = a1_ext[13:1];
                        state_next = S_WB;
                    end
                end
                else
                begin
                    if (second_reg && (st_reg == ST_OK))
                    begin
                        st_next = s1_reg;
                    end
                    state_next = S_FINAL;
                end
            end

            S_REP:
            begin
                mem.cache_we    = 1'b1;
                mem.waddr       = {7'd0, data_reg[14:9]};
                mem.cache_wdata = data_reg[8] ? {data_reg[7:0], rw[7:0]}
                                              : {rw[15:8], data_reg[7:0]};
                state_next      = S_FINAL;
            end

            S_FINAL:
            begin
                valid_next        = 1'b1;
                res_next.kind     = KIND_FINAL;
                res_next.data_res = rd_reg;
                res_next.status   = st_reg;
                res_next.last     = 1'b1;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cnt_reg         <= '0;
            fin_reg         <= 1'b0;
            func_reg        <= '0;
            addr_reg        <= '0;
            data_reg        <= '0;
            cur_a_reg       <= '0;
            cur_b_reg       <= '0;
            second_reg      <= 1'b0;
            s1_reg          <= '0;
            st_reg          <= '0;
            rd_reg          <= '0;
            pend_b2_reg     <= 1'b0;
            lw_v_reg        <= '0;
            slot_reg        <= '0;
            replay_done_reg <= 1'b0;
            pending_reg     <= 1'b0;
            pwa_reg         <= '0;
            res_reg         <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            fin_reg         <= fin_next;
            func_reg        <= func_next;
            addr_reg        <= addr_next;
            data_reg        <= data_next;
            cur_a_reg       <= cur_a_next;
            cur_b_reg       <= cur_b_next;
            second_reg      <= second_next;
            s1_reg          <= s1_next;
            st_reg          <= st_next;
            rd_reg          <= rd_next;
            pend_b2_reg     <= pend_b2_next;
            lw_v_reg        <= lw_v_next;
            slot_reg        <= slot_next;
            replay_done_reg <= replay_done_next;
            pending_reg     <= pending_next;
            pwa_reg         <= pwa_next;
            res_reg         <= res_next;
            valid_reg       <= valid_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign result       = res_reg;

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_ext <= LOG_LIM)
        else $error("log slot beyond log size");

    a_log_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == KIND_LOG)) |-> ({1'b0, result.word_index} < 14'(LOG_WORDS)))
        else $error("log program outside log area");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("final result while still busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make block busy");

endmodule

`default_nettype wire
